@@ hdl/vgou_pkg.sv @@
// ----------------------------------------------------------------------------
// vgou_pkg: shared types and constants for the voxel occlusion update unit
// Holds default geometry, command and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package vgou_pkg;

    localparam int CHUNK_EDGE_DEF    = 8;
    localparam int CHUNKS_ACROSS_DEF = 6;

    localparam logic [1:0] CMD_PLACE   = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;
    localparam logic [1:0] ST_AIR      = 2'd3;

    // One classified transaction handed from the front to the back part.
    // The rebased x and z need eight bits for the widest world.
    typedef struct packed {
        logic [1:0] command;
        logic       outside;
        logic [7:0] rx;
        logic [6:0] ry;
        logic [7:0] rz;
        logic [3:0] new_type;
    } t_job;

endpackage

@@ hdl/vgou_if.sv @@
// ----------------------------------------------------------------------------
// vgou_cmd_if / vgou_res_if: valid-ready channels of the unit
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface vgou_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic signed [6:0] pos_x;
    logic signed [6:0] pos_y;
    logic signed [6:0] pos_z;
    logic [3:0] new_type;
    modport source (output valid, command, pos_x, pos_y, pos_z, new_type, input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, new_type, output ready);
endinterface

interface vgou_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] voxel_kind;
    logic       hidden;
    modport source (output valid, status, voxel_kind, hidden, input ready);
    modport sink   (input valid, status, voxel_kind, hidden, output ready);
endinterface

@@ hdl/vgou_front.sv @@
// ----------------------------------------------------------------------------
// vgou_front: command intake and classification
// Checks the target against the world bounds, rebases the coordinates and
// pushes the transaction into a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module vgou_front #(
    parameter int CHUNK_EDGE    = vgou_pkg::CHUNK_EDGE_DEF,
    parameter int CHUNKS_ACROSS = vgou_pkg::CHUNKS_ACROSS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vgou_cmd_if.sink         cmd,
    output logic             o_job_valid,
    input  logic             i_job_take,
    output vgou_pkg::t_job   o_job
);
    localparam int SPAN = CHUNK_EDGE * CHUNKS_ACROSS;
    localparam int LO   = -((SPAN + 1) / 2);

    vgou_pkg::t_job r_q [2];
    logic           r_rd, r_wr;
    logic [1:0]     r_cnt;
    logic signed [9:0] sx, sy, sz;
    vgou_pkg::t_job job;
    logic push, pop;

    always_comb begin
        sx = 10'(cmd.pos_x) - 10'(LO);
        sy = 10'(cmd.pos_y);
        sz = 10'(cmd.pos_z) - 10'(LO);
        job.command  = cmd.command;
        job.outside  = (cmd.command == vgou_pkg::CMD_UNUSED) ||
                       sx < 0 || sx >= 10'(SPAN) || sy < 0 || sy >= 10'(CHUNK_EDGE) ||
                       sz < 0 || sz >= 10'(SPAN);
        job.rx       = sx[7:0];
        job.ry       = sy[6:0];
        job.rz       = sz[7:0];
        job.new_type = cmd.new_type;
    end

    assign cmd.ready   = (r_cnt != 2'd2);
    assign push        = cmd.valid && cmd.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !pop) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push) else $error("push into full queue");
`endif
endmodule

@@ hdl/vgou_back.sv @@
// ----------------------------------------------------------------------------
// vgou_back: voxel store sequencer
// Carries out one transaction at a time against the voxel store, at most one
// memory access per cycle, recomputing hidden flags around the target.
// ----------------------------------------------------------------------------
module vgou_back #(
    parameter int CHUNK_EDGE    = vgou_pkg::CHUNK_EDGE_DEF,
    parameter int CHUNKS_ACROSS = vgou_pkg::CHUNKS_ACROSS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_take,
    input  vgou_pkg::t_job i_job,
    vgou_res_if.source     res,
    output logic           o_clearing
);
    localparam int SPAN  = CHUNK_EDGE * CHUNKS_ACROSS;
    localparam int DEPTH = SPAN * SPAN * CHUNK_EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SPAN);
    localparam int YW    = $clog2(CHUNK_EDGE);
    localparam int EW    = (CW > YW) ? CW : YW;
    // Reciprocal of the chunk edge in 16 fractional bits, rounded up; exact
    // for every coordinate below 2048, far beyond the widest world.
    localparam int DMUL  = (65536 + CHUNK_EDGE - 1) / CHUNK_EDGE;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_TGT = 4'd2, S_TGTW = 4'd3,
                           S_CTR = 4'd4, S_NB = 4'd5, S_NBW = 4'd6, S_NN = 4'd7,
                           S_NNW = 4'd8, S_NWR = 4'd9, S_RD = 4'd10, S_RDW = 4'd11,
                           S_OUT = 4'd12;

    // Store entry: {hidden, type}.
    logic [4:0] r_mem [DEPTH];
    logic [4:0] r_rdata;

    logic [3:0]    r_state;
    logic [AW-1:0] r_clr;
    vgou_pkg::t_job r_job;
    logic [2:0]    r_k, r_j;
    logic          r_all;
    logic [4:0]    r_tgt;
    logic [1:0]    r_status;
    logic [CW-1:0] r_nx, r_nz;
    logic [YW-1:0] r_ny;
    logic          r_nin;
    logic [AW-1:0] r_naddr;
    logic          r_ctr;
    // Type of the neighbour being refreshed, written back with its new flag.
    logic [3:0]    r_nbtype;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [4:0]    wdata;

    // Chunk number and offset within the chunk along x or z.
    function automatic logic [CW-1:0] div_edge(logic [CW-1:0] v);
        logic [CW+15:0] p;
        p = (CW+16)'(v) * (CW+16)'(DMUL);
        return p[CW+15:16];
    endfunction

    function automatic logic [CW-1:0] rem_edge(logic [CW-1:0] v);
        logic [CW+5:0] m;
        m = (CW+6)'(div_edge(v)) * (CW+6)'(CHUNK_EDGE);
        return v - m[CW-1:0];
    endfunction

    // Voxel address from rebased coordinates.
    function automatic logic [AW-1:0] addr_of(logic [CW-1:0] x, logic [YW-1:0] y,
                                             logic [CW-1:0] z);
        logic [AW+CW:0] a;
        a = ((AW+CW+1)'(div_edge(x)) * (AW+CW+1)'(CHUNKS_ACROSS)
             + (AW+CW+1)'(div_edge(z)))
            * (AW+CW+1)'(CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE)
            + (AW+CW+1)'(rem_edge(x)) + (AW+CW+1)'(y) * (AW+CW+1)'(CHUNK_EDGE)
            + (AW+CW+1)'(rem_edge(z)) * (AW+CW+1)'(CHUNK_EDGE * CHUNK_EDGE);
        return a[AW-1:0];
    endfunction

    // Step from a centre by direction k; sets in-world flag.
    typedef struct packed {
        logic          inw;
        logic [CW-1:0] x;
        logic [YW-1:0] y;
        logic [CW-1:0] z;
    } t_pt;

    function automatic t_pt step(logic [CW-1:0] x, logic [YW-1:0] y, logic [CW-1:0] z,
                                 logic [2:0] k);
        t_pt p;
        logic signed [EW+1:0] vx, vy, vz;
        vx = $signed({2'b00, EW'(x)});
        vy = $signed({2'b00, EW'(y)});
        vz = $signed({2'b00, EW'(z)});
        case (k)
            3'd0:    vx = vx - (EW+2)'(1);
            3'd1:    vx = vx + (EW+2)'(1);
            3'd2:    vy = vy - (EW+2)'(1);
            3'd3:    vy = vy + (EW+2)'(1);
            3'd4:    vz = vz - (EW+2)'(1);
            default: vz = vz + (EW+2)'(1);
        endcase
        p.inw = vx >= 0 && vx < (EW+2)'(SPAN) && vy >= 0 && vy < (EW+2)'(CHUNK_EDGE)
                && vz >= 0 && vz < (EW+2)'(SPAN);
        p.x = vx[CW-1:0];
        p.y = vy[YW-1:0];
        p.z = vz[CW-1:0];
        return p;
    endfunction

    logic [CW-1:0] tx, tz;
    logic [YW-1:0] ty;
    logic [AW-1:0] taddr;
    t_pt pn, pnn;
    logic [3:0] eff_type;

    always_comb begin
        tx = r_job.rx[CW-1:0];
        ty = r_job.ry[YW-1:0];
        tz = r_job.rz[CW-1:0];
        taddr = addr_of(tx, ty, tz);
        pn  = step(tx, ty, tz, r_k);
        pnn = step(r_ctr ? tx : r_nx, r_ctr ? ty : r_ny, r_ctr ? tz : r_nz, r_j);
        // Target type as updated, seen when a neighbour scan reaches it.
        eff_type = (r_job.command == vgou_pkg::CMD_PLACE) ? r_job.new_type : 4'd0;
        we = 1'b0; re = 1'b0; waddr = taddr; raddr = taddr; wdata = 5'd0;
        case (r_state)
            S_CLEAR: begin we = 1'b1; waddr = r_clr; end
            S_TGT:   re = 1'b1;
            S_NB:    begin re = pn.inw; raddr = addr_of(pn.x, pn.y, pn.z); end
            S_NN:    begin re = pnn.inw; raddr = addr_of(pnn.x, pnn.y, pnn.z); end
            S_NWR: begin
                we = 1'b1;
                waddr = r_ctr ? taddr : r_naddr;
                wdata = r_ctr ? {r_all, eff_type} : {r_all, r_nbtype};
            end
            S_RD:    re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    logic nn_solid;
    assign nn_solid = r_nin && (r_rdata[3:0] != 4'd0);
    assign o_job_take = (r_state == S_IDLE);
    assign o_clearing = (r_state == S_CLEAR);
    assign res.valid  = (r_state == S_OUT);
    assign res.status = r_status;
    assign res.voxel_kind = r_job.outside ? 4'd0 : r_tgt[3:0];
    assign res.hidden     = r_job.outside ? 1'b0 : r_tgt[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_k <= 3'd0;
                    r_status <= i_job.outside ? vgou_pkg::ST_OUTSIDE : vgou_pkg::ST_DONE;
                    r_state <= i_job.outside ? S_OUT : S_TGT;
                end
                S_TGT:  r_state <= S_TGTW;
                S_TGTW: begin
                    r_tgt <= r_rdata;
                    if (r_job.command == vgou_pkg::CMD_PLACE && r_rdata[3:0] != 4'd0) begin
                        r_status <= vgou_pkg::ST_OCCUPIED;
                        r_state <= S_OUT;
                    end else if (r_job.command == vgou_pkg::CMD_DESTROY
                                 && r_rdata[3:0] == 4'd0) begin
                        r_status <= vgou_pkg::ST_AIR;
                        r_state <= S_OUT;
                    end else if (r_job.command == vgou_pkg::CMD_PLACE) begin
                        r_ctr <= 1'b1; r_j <= 3'd0; r_all <= 1'b1;
                        r_state <= S_NN;
                    end else if (r_job.command == vgou_pkg::CMD_DESTROY) begin
                        r_ctr <= 1'b0;
                        r_state <= S_CTR;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // Write the destroyed target as air, flag kept.
                S_CTR: begin
                    r_ctr <= 1'b1; r_all <= r_tgt[4];
                    r_state <= S_NWR;
                end
                S_NB: begin
                    r_nx <= pn.x; r_ny <= pn.y; r_nz <= pn.z; r_nin <= pn.inw;
                    r_naddr <= addr_of(pn.x, pn.y, pn.z);
                    r_state <= S_NBW;
                end
                S_NBW: begin
                    if (nn_solid) begin
                        r_j <= 3'd0; r_all <= 1'b1; r_state <= S_NN;
                    end else if (r_k == 3'd5) begin
                        r_state <= S_RD;
                    end else begin
                        r_k <= r_k + 3'd1; r_state <= S_NB;
                    end
                    r_tgt[3:0] <= r_rdata[3:0];
                end
                S_NN: begin
                    r_nin <= pnn.inw;
                    r_state <= S_NNW;
                end
                S_NNW: begin
                    if (!nn_solid) r_all <= 1'b0;
                    if (r_j == 3'd5) r_state <= S_NWR;
                    else begin r_j <= r_j + 3'd1; r_state <= S_NN; end
                end
                S_NWR: begin
                    r_nin <= 1'b1;
                    if (r_ctr) begin
                        r_ctr <= 1'b0; r_k <= 3'd0; r_state <= S_NB;
                    end else if (r_k == 3'd5) begin
                        r_state <= S_RD;
                    end else begin
                        r_k <= r_k + 3'd1; r_state <= S_NB;
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: begin r_tgt <= r_rdata; r_state <= S_OUT; end
                S_OUT: if (res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The neighbour scan overwrites r_rdata, so the neighbour's own type is
    // kept from the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_NBW) r_nbtype <= r_rdata[3:0];
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && !res.ready |=> res.valid) else $error("result dropped");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> !res.valid) else $error("intake while result pending");
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_clearing) |=> !o_clearing) else $error("clearing resumed");
    a_we_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re)) else $error("read and write in one cycle");
`endif
endmodule

@@ hdl/voxel_grid_occlusion_update_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_occlusion_update_unit: voxel grid with hidden-face flags
// Place, destroy and query on a chunked voxel store, keeping per-voxel hidden
// flags up to date for the target and its six face neighbours.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  cmd      in         command, pos_x, pos_y, pos_z, new_type
//  res      out        status, voxel_kind, hidden
//
//  From taking a transaction to offering its result the sequencer goes
//  straight to the result for a target outside the world or the unused code,
//  reads only the target for a query or a rejected command, and for a place
//  or destroy also refreshes the hidden flags around the target. The voxel
//  store has a single port, walked at most one access per cycle. After reset
//  the store, CHUNK_EDGE^3 * CHUNKS_ACROSS^2 voxels (18432 by default), is
//  cleared one voxel per cycle, during which
//  commands queue but are not executed. A two-entry queue lets the intake
//  accept transactions while a result waits on a stalled output.
module voxel_grid_occlusion_update_unit #(
    parameter int CHUNK_EDGE    = vgou_pkg::CHUNK_EDGE_DEF,
    parameter int CHUNKS_ACROSS = vgou_pkg::CHUNKS_ACROSS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vgou_cmd_if.sink   cmd,
    vgou_res_if.source res
);
    logic           job_valid, job_take, clearing;
    vgou_pkg::t_job job;

    // Classify and queue incoming transactions.
    vgou_front #(.CHUNK_EDGE(CHUNK_EDGE), .CHUNKS_ACROSS(CHUNKS_ACROSS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd),
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job));

    // Execute them against the voxel store.
    vgou_back #(.CHUNK_EDGE(CHUNK_EDGE), .CHUNKS_ACROSS(CHUNKS_ACROSS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid),
        .o_job_take(job_take), .i_job(job), .res(res), .o_clearing(clearing));

`ifndef ASSERT_OFF
    a_no_res_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !res.valid) else $error("result during clearing");
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !job_take) else $error("job taken during clearing");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take && job_valid |=> !job_take) else $error("double take");
`endif
endmodule
